/* design/crd_pkg.sv */
package crd_pkg;

  // Stream widths on the top-level ports.
  localparam int S_DATA_W = 8;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 104;
  localparam int M_USER_W = 1;

  // Bit places within s_tuser.
  localparam int S_USER_START   = 0;
  localparam int S_USER_BATTERY = 1;

  // Frame layout.
  localparam logic [3:0] POS_COMMAND   = 4'd3;
  localparam logic [3:0] PAYLOAD_FIRST = 4'd4;
  localparam logic [3:0] PAYLOAD_LAST  = 4'd11;
  localparam logic [3:0] LAST_ODOMETER = 4'd13;
  localparam logic [3:0] LAST_BATTERY  = 4'd9;
  localparam int         PAYLOAD_N     = 8;

  localparam logic [7:0] ODOMETER_REPLY_CMD = 8'h12;
  localparam logic [7:0] BATTERY_REPLY_CMD  = 8'h08;
  localparam logic [7:0] CRC_POLY           = 8'h8C;

  // Result queue between the parser and the output stage.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_BAD_CMD = 2'd2
  } status_t;

  typedef struct packed {
    logic        battery;
    status_t     status;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
  } result_t;

  // Reflected CRC-8, one byte per call, eight bit steps.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/crd_front.sv */
module crd_front
  import crd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic         frame_start,
  input  logic         expect_battery,
  output logic         push,
  output result_t      result
);

  logic [3:0] pos;
  logic       in_frame;
  logic [7:0] crc;
  logic       battery;
  logic [7:0] cmd;
  logic [7:0] payload [PAYLOAD_N];

  logic       eff_in;
  logic [3:0] eff_pos;
  logic [7:0] eff_crc;
  logic       eff_batt;
  logic [7:0] eff_cmd;
  logic [3:0] last_pos;
  logic       is_body;
  logic [3:0] pos_off;
  logic       in_payload;
  logic [7:0] cmd_expected;

  // A start flag overrides whatever frame was open.
  always_comb begin
    eff_in       = frame_start | in_frame;
    eff_pos      = frame_start ? 4'd0 : pos;
    eff_crc      = frame_start ? 8'd0 : crc;
    eff_batt     = frame_start ? expect_battery : battery;
    eff_cmd      = frame_start ? 8'd0 : cmd;
    last_pos     = eff_batt ? LAST_BATTERY : LAST_ODOMETER;
    is_body      = eff_pos < last_pos;
    pos_off      = eff_pos - PAYLOAD_FIRST;
    in_payload   = (eff_pos >= PAYLOAD_FIRST) && (eff_pos <= PAYLOAD_LAST);
    cmd_expected = eff_batt ? BATTERY_REPLY_CMD : ODOMETER_REPLY_CMD;
  end

  assign push = accept && eff_in && !is_body;

  always_comb begin
    result.battery = eff_batt;
    if (rx_byte != eff_crc) begin
      result.status = STATUS_CRC_ERR;
    end else if (eff_cmd != cmd_expected) begin
      result.status = STATUS_BAD_CMD;
    end else begin
      result.status = STATUS_OK;
    end
    result.word0 = {payload[0], payload[1]};
    result.word1 = {payload[2], payload[3]};
    result.word2 = {payload[4], payload[5]};
    result.word3 = {payload[6], payload[7]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      in_frame <= 1'b0;
      crc      <= '0;
      battery  <= 1'b0;
      cmd      <= '0;
    end else if (accept && eff_in) begin
      battery <= eff_batt;
      if (is_body) begin
        in_frame <= 1'b1;
        pos      <= eff_pos + 4'd1;
        crc      <= crc8_update(eff_crc, rx_byte);
        cmd      <= (eff_pos == POS_COMMAND) ? rx_byte : eff_cmd;
      end else begin
        in_frame <= 1'b0;
        pos      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && eff_in && is_body && in_payload) begin
      payload[pos_off[2:0]] <= rx_byte;
    end
  end

endmodule

/* design/crd_queue.sv */
module crd_queue
  import crd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output result_t data
);

  result_t           store [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign valid   = (count != '0);
  assign data    = store[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

/* design/crd_back.sv */
module crd_back
  import crd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  result_t             q_data,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser
);

  logic        kind;
  status_t     status;
  logic [15:0] vel_x;
  logic [15:0] vel_y;
  logic [15:0] yaw;
  logic [15:0] rate_z;
  logic [15:0] voltage;
  logic [15:0] current;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= q_valid;
    end
  end

  // Fields of the other frame kind read as zero.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind    <= q_data.battery;
      status  <= q_data.status;
      vel_x   <= q_data.battery ? 16'd0 : q_data.word0;
      vel_y   <= q_data.battery ? 16'd0 : q_data.word1;
      yaw     <= q_data.battery ? 16'd0 : q_data.word2;
      rate_z  <= q_data.battery ? 16'd0 : q_data.word3;
      voltage <= q_data.battery ? q_data.word0 : 16'd0;
      current <= q_data.battery ? q_data.word1 : 16'd0;
    end
  end

  assign m_tdata = {6'd0, current, voltage, rate_z, yaw, vel_y, vel_x, status};
  assign m_tuser = kind;

endmodule

/* design/chassis_response_decoder.sv */
// Chassis reply decoder. Each beat on the slave side carries one received byte of a
// reply frame; a beat with the start flag opens a frame and samples whether a 10-byte
// battery reply or a 14-byte odometer reply follows, dropping any frame still open. A
// reflected CRC-8 (polynomial 0x8C, initial value zero) runs over every byte but the
// last, which is compared against it. On the final byte one result beat is produced
// with the frame kind, a status (ok, CRC mismatch, or CRC good but wrong command byte)
// and the big-endian signed fields of the frame; fields of the other kind read as
// zero. Bytes arriving outside a frame are taken and ignored. The block accepts one
// byte every clock cycle while s_tready is high: the parser updates its CRC and byte
// counter as each byte is taken, and a result passes through the result queue and
// the output register on its way to the master side. The two-entry queue sits
// between the parser and the output register, so s_tready only falls when two
// finished results are waiting behind a stalled master side.
module chassis_response_decoder
  import crd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] rx_byte
  input  logic [S_USER_W-1:0] s_tuser,   // [0] frame_start, [1] expect_battery
  output logic                m_tvalid,
  input  logic                m_tready,
  // [1:0] status, [17:2] vel_x, [33:18] vel_y, [49:34] yaw, [65:50] rate_z,
  // [81:66] voltage, [97:82] current, [103:98] zero
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser    // [0] frame_kind
);

  logic    accept;
  logic    push;
  result_t push_data;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t q_data;

  // The parser never stalls on its own; only a full result queue holds it off.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  crd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .rx_byte        (s_tdata[7:0]),
    .frame_start    (s_tuser[S_USER_START]),
    .expect_battery (s_tuser[S_USER_BATTERY]),
    .push           (push),
    .result         (push_data)
  );

  crd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  crd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* design/crd_checker.sv */
module crd_checker
  import crd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [M_USER_W-1:0] m_tuser
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat withdrawn while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("undefined status code on a result beat");

  a_battery_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[65:2] == '0) && (m_tdata[103:98] == '0))
    else $error("battery result carries odometer fields");

  a_odometer_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[97:66] == '0) && (m_tdata[103:98] == '0))
    else $error("odometer result carries battery fields");

endmodule

bind chassis_response_decoder crd_checker u_crd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* sim/chassis_response_decoder_checker.sv */
`timescale 1ns / 1ps
// Watches both streams of the chassis reply decoder. It keeps its own copy of the
// frame parser, queues the reply that each final byte should produce, and checks
// every result beat against the oldest queued reply.
module chassis_response_decoder_checker
  import crd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,
  input  logic [M_USER_W-1:0] m_tuser,
  output int                  mismatches,
  output int                  replies_owed
);

  localparam logic [7:0] CRC_REFLECTED = 8'h8C;
  localparam logic [3:0] COMMAND_POS   = 4'd3;
  localparam logic [3:0] FIELDS_FIRST  = 4'd4;
  localparam logic [3:0] FIELDS_LAST   = 4'd11;
  localparam logic [3:0] ODO_FINAL     = 4'd13;
  localparam logic [3:0] BATT_FINAL    = 4'd9;

  typedef struct packed {
    logic        battery;
    status_t     status;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw;
    logic [15:0] rate_z;
    logic [15:0] voltage;
    logic [15:0] current;
  } reply_t;

  logic [3:0] frame_pos;
  logic       frame_open;
  logic [7:0] crc_acc;
  logic       is_battery;
  logic [7:0] command_byte;
  logic [7:0] field_bytes [8];
  reply_t     replies_due [$];

  // Bit-serial form of the reflected CRC: each input bit, lowest first, is folded
  // into the feedback term.
  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[7:1]};
      if (fb) c = c ^ CRC_REFLECTED;
    end
    return c;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic start, input logic batt);
    logic [3:0] final_pos;
    reply_t     r;
    if (start) begin
      frame_open   = 1'b1;
      frame_pos    = '0;
      crc_acc      = '0;
      is_battery   = batt;
      command_byte = '0;
    end
    if (!frame_open) return;
    final_pos = is_battery ? BATT_FINAL : ODO_FINAL;
    if (frame_pos < final_pos) begin
      crc_acc = crc8_maxim(crc_acc, b);
      if (frame_pos == COMMAND_POS) command_byte = b;
      if (frame_pos >= FIELDS_FIRST && frame_pos <= FIELDS_LAST)
        field_bytes[3'(frame_pos - FIELDS_FIRST)] = b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      r = '0;
      r.battery = is_battery;
      if (b != crc_acc)
        r.status = STATUS_CRC_ERR;
      else if (command_byte != (is_battery ? BATTERY_REPLY_CMD : ODOMETER_REPLY_CMD))
        r.status = STATUS_BAD_CMD;
      else
        r.status = STATUS_OK;
      if (is_battery) begin
        r.voltage = {field_bytes[0], field_bytes[1]};
        r.current = {field_bytes[2], field_bytes[3]};
      end else begin
        r.vel_x  = {field_bytes[0], field_bytes[1]};
        r.vel_y  = {field_bytes[2], field_bytes[3]};
        r.yaw    = {field_bytes[4], field_bytes[5]};
        r.rate_z = {field_bytes[6], field_bytes[7]};
      end
      replies_due.push_back(r);
      frame_open = 1'b0;
      frame_pos  = '0;
    end
  endtask

  task automatic field_check(input string name, input logic [15:0] want, input logic [15:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, seen);
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with no reply expected, got kind %b data %h",
               $time, m_tuser, m_tdata);
      return;
    end
    want = replies_due.pop_front();
    field_check("frame_kind", 16'(want.battery), 16'(m_tuser[0]));
    field_check("status", 16'(want.status), 16'(m_tdata[1:0]));
    field_check("vel_x", want.vel_x, m_tdata[17:2]);
    field_check("vel_y", want.vel_y, m_tdata[33:18]);
    field_check("yaw", want.yaw, m_tdata[49:34]);
    field_check("rate_z", want.rate_z, m_tdata[65:50]);
    field_check("voltage", want.voltage, m_tdata[81:66]);
    field_check("current", want.current, m_tdata[97:82]);
    field_check("padding", 16'h0000, 16'(m_tdata[103:98]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_pos    = '0;
      frame_open   = 1'b0;
      crc_acc      = '0;
      is_battery   = 1'b0;
      command_byte = '0;
      for (int i = 0; i < 8; i++) field_bytes[i] = '0;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_reply();
      if (s_tvalid && s_tready)
        take_byte(s_tdata, s_tuser[S_USER_START], s_tuser[S_USER_BATTERY]);
    end
    replies_owed = replies_due.size();
  end

endmodule

/* sim/chassis_response_decoder_tb.sv */
`timescale 1ns / 1ps
module chassis_response_decoder_tb;
  import crd_pkg::*;

  // Rough stimulus volume in received bytes; the random part stops once it is reached.
  localparam int N_BYTES      = 850;
  // The receiver refuses results for a long stretch after this many result beats,
  // long enough for the result queue to fill and the decoder to stall its input.
  localparam int HOLD_AT      = 20;
  localparam int HOLD_CYCLES  = 800;
  // At this frame of the random part the sender waits until every reply is home.
  localparam int PAUSE_FRAME  = 40;

  localparam logic [7:0] CRC_REFLECTED = 8'h8C;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  int         mismatches;
  int         replies_owed;
  int         bytes_sent = 0;
  // While set, the sender offers bytes back to back with no idle cycles.
  logic       burst = 1'b0;
  // The frame being sent; the final byte is filled in with the CRC on sending.
  logic [7:0] frame_buf [14];

  always #5 clk = ~clk;

  chassis_response_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  chassis_response_decoder_checker reply_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .replies_owed (replies_owed)
  );

  // Offers one byte after a random idle gap and holds it until the decoder takes it.
  // Inputs change only at the falling edge; the handshake is judged at the rising
  // edge, before any register in the decoder has moved.
  task automatic send_byte(input logic [7:0] b, input logic start, input logic batt);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {batt, start};   // bit 1 battery expected, bit 0 start of frame
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Sends the first `count` bytes of the frame in frame_buf. The final byte is the
  // CRC of all the others, spoilt on purpose when crc_good is clear. A count short
  // of the full length leaves the frame open, to be dropped by the next start.
  task automatic send_frame(input logic batt, input logic crc_good, input int count);
    int         len;
    logic [7:0] crc;
    logic       fb;
    len = batt ? 10 : 14;
    crc = 8'h00;
    for (int i = 0; i < len - 1; i++) begin
      for (int k = 0; k < 8; k++) begin
        fb  = crc[0] ^ frame_buf[i][k];
        crc = {1'b0, crc[7:1]} ^ (fb ? CRC_REFLECTED : 8'h00);
      end
    end
    frame_buf[len - 1] = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < count; i++)
      send_byte(frame_buf[i], i == 0, (i == 0) ? batt : 1'($urandom_range(0, 1)));
  endtask

  // Random byte with a bias towards the values at the edges of a signed field.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Fills frame_buf with random content. The command byte is mostly the right one,
  // now and then the one of the other kind, and sometimes any byte at all.
  task automatic fill_random_frame(input logic batt);
    int roll;
    for (int i = 0; i < 14; i++) frame_buf[i] = pick_byte();
    roll = $urandom_range(0, 99);
    if (roll < 85)
      frame_buf[3] = batt ? BATTERY_REPLY_CMD : ODOMETER_REPLY_CMD;
    else if (roll < 92)
      frame_buf[3] = batt ? ODOMETER_REPLY_CMD : BATTERY_REPLY_CMD;
    else
      frame_buf[3] = 8'($urandom);
  endtask

  // Waits until the checker holds no outstanding reply. The first falling edge
  // keeps the test clear of the rising edge at which the last byte was taken.
  task automatic drain();
    @(negedge clk);
    while (replies_owed != 0) @(negedge clk);
  endtask

  // Sender: reset, a short directed part, then frames of random make-up.
  initial begin
    int  frames;
    int  roll;
    int  count;
    logic batt;
    frames = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Stray bytes before any frame has opened are swallowed without a result.
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    // An odometer frame cut short: the start of the next frame drops it.
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    // A sound battery reply carrying the most negative voltage and the largest
    // current; the odometer fields of the result must read as zero.
    frame_buf = '{8'h7B, 8'h00, 8'hFF, BATTERY_REPLY_CMD, 8'h80, 8'h00, 8'h7F, 8'hFF,
                  8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(1'b1, 1'b1, 10);
    // An odometer reply with a spoilt CRC and every field at an edge value; the
    // battery fields of the result must read as zero.
    frame_buf = '{8'h7B, 8'hFF, 8'h00, ODOMETER_REPLY_CMD, 8'hFF, 8'hFF, 8'h00, 8'h00,
                  8'h7F, 8'hFF, 8'h80, 8'h00, 8'h5A, 8'h00};
    send_frame(1'b0, 1'b0, 14);
    drain();

    while (bytes_sent < N_BYTES) begin
      if (frames == PAUSE_FRAME) drain();
      if ($urandom_range(0, 3) == 0) burst = ~burst;
      roll = $urandom_range(0, 99);
      batt = 1'($urandom_range(0, 1));
      if (roll < 6) begin
        // Noise: ignored if no frame is open, otherwise taken as frame bytes.
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        fill_random_frame(batt);
        count = batt ? 10 : 14;
        if (roll < 16) count = $urandom_range(1, count - 1);
        send_frame(batt, $urandom_range(0, 99) >= 12, count);
      end
      frames++;
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_owed == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: a random number of idle cycles before each result beat, stretches of
  // constant readiness, and one long hold-off counted here in cycles.
  initial begin
    int   results;
    int   hold;
    logic quiet;
    results = 0;
    quiet   = 1'b0;
    forever begin
      if (results == HOLD_AT)
        hold = HOLD_CYCLES;
      else if (quiet)
        hold = 0;
      else
        hold = $urandom_range(0, 16);
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results++;
      if ($urandom_range(0, 15) == 0) quiet = ~quiet;
    end
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
design/crd_pkg.sv
design/crd_front.sv
design/crd_queue.sv
design/crd_back.sv
design/chassis_response_decoder.sv
design/crd_checker.sv
sim/chassis_response_decoder_checker.sv
sim/chassis_response_decoder_tb.sv
